>>> rtl/lce_pkg.sv
// Shared constants, register indexes and control structs of the line center estimator.
`timescale 1ns / 1ps

package lce_pkg;

   // Sensor array
   localparam int N_SENSORS = 8;
   localparam int IDX_W     = (N_SENSORS > 2) ? $clog2(N_SENSORS) : 1;
   localparam int WGT_W     = IDX_W + 2;
   localparam int TIME_W    = 16;
   localparam int SLOTS     = 4;                  // sensor times per calibration register

   // Reflectance and sums
   localparam int REFL_W    = 13;                 // 0 .. 4096
   localparam int REFL_SH   = 12;                 // Q1.12
   localparam int SUM_W     = 18;                 // signed weighted sum
   localparam int TOT_W     = 16;                 // total reflectance, up to 8 * 4096

   // Centroid
   localparam int CEN_W     = 16;
   localparam int CEN_SH    = 14;                 // Q2.14
   localparam logic signed [CEN_W-1:0] CEN_POS = CEN_W'(16384);
   localparam logic signed [CEN_W-1:0] CEN_NEG = -CEN_W'(16384);

   // Shared divider
   localparam int DVD_W     = 31;
   localparam int DVS_W     = 18;
   localparam int QUO_W     = 15;
   localparam int CNT_W     = 4;

   // Register port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int LVL_W      = 16;
   localparam logic [CSR_IDX_W-1:0] REG_WHITE_LO = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WHITE_HI = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BLACK_LO = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BLACK_HI = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_LVL  = 3'd4;
   localparam logic [LVL_W-1:0]     MIN_LVL_RST  = 16'd2048;

   // Controller to datapath
   typedef struct packed {
      logic load;        // capture sweep, clear sums
      logic refl_start;  // start divide for current sensor
      logic refl_acc;    // accumulate current sensor, step index
      logic cen_start;   // start centroid divide
      logic finish;      // write result word
   } lce_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic div_done;
      logic last_sensor;
      logic no_line;
      logic out_free;
   } lce_sts_type;

endpackage

>>> rtl/lce_div.sv
// Restoring divider, one quotient bit per cycle, shared by reflectance and centroid.
`timescale 1ns / 1ps

module lce_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [lce_pkg::DVD_W-1:0]  dividend,
   input  logic [lce_pkg::DVS_W-1:0]  divisor,
   output logic [lce_pkg::QUO_W-1:0]  quotient,
   output logic                       done
);
   import lce_pkg::*;

   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] lo_ff, lo_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;
   logic             fits;

   // trial subtract of the next remainder bit
   assign trial = {rem_ff, lo_ff[QUO_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = busy_ff && (cnt_ff == CNT_W'(1));
      if (start) begin
         // quotient fits in QUO_W bits, so the upper dividend bits start below the divisor
         rem_in  = DVS_W'(dividend[DVD_W-1:QUO_W]);
         lo_in   = dividend[QUO_W-1:0];
         dvs_in  = divisor;
         cnt_in  = CNT_W'(QUO_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         lo_in  = {lo_ff[QUO_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = lo_ff;
   assign done     = done_ff;

endmodule

>>> rtl/lce_datapath.sv
// Datapath: calibration registers, sweep capture, reflectance, sums, centroid and result word.
`timescale 1ns / 1ps

module lce_datapath (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        csr_we,
   input  logic [lce_pkg::CSR_IDX_W-1:0]               csr_index,
   input  logic [lce_pkg::CSR_DATA_W-1:0]              csr_wdata,
   input  logic [lce_pkg::N_SENSORS*lce_pkg::TIME_W-1:0] sweep,
   input  lce_pkg::lce_cmd_type                        cmd,
   output lce_pkg::lce_sts_type                        sts,
   input  logic                                        rsp_tready,
   output logic                                        rsp_tvalid,
   output logic [lce_pkg::CEN_W-1:0]                   rsp_tdata,
   output logic [0:0]                                  rsp_tuser
);
   import lce_pkg::*;

   localparam logic signed [WGT_W-1:0] WGT_OFS = WGT_W'(N_SENSORS - 1);

   logic [TIME_W-1:0]       white_ff [N_SENSORS];
   logic [TIME_W-1:0]       black_ff [N_SENSORS];
   logic [TIME_W-1:0]       time_ff  [N_SENSORS];
   logic [LVL_W-1:0]        min_lvl_ff;

   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [TOT_W-1:0]        total_ff, total_in;
   logic signed [CEN_W-1:0] last_ff, last_in;
   logic                    valid_ff, valid_in;
   logic signed [CEN_W-1:0] center_ff, center_in;
   logic                    found_ff, found_in;

   // calibration registers, sensor k in slot k mod 4 of its low or high word
   for (genvar k = 0; k < N_SENSORS; k++) begin : g_cal
      localparam int SLOT = k % SLOTS;
      localparam logic [CSR_IDX_W-1:0] W_REG = (k < SLOTS) ? REG_WHITE_LO : REG_WHITE_HI;
      localparam logic [CSR_IDX_W-1:0] B_REG = (k < SLOTS) ? REG_BLACK_LO : REG_BLACK_HI;
      always_ff @(posedge clock) begin
         if (reset) begin
            white_ff[k] <= '0;
            black_ff[k] <= '0;
         end else begin
            if (csr_we && (csr_index == W_REG)) begin
               white_ff[k] <= csr_wdata[SLOT*TIME_W +: TIME_W];
            end
            if (csr_we && (csr_index == B_REG)) begin
               black_ff[k] <= csr_wdata[SLOT*TIME_W +: TIME_W];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_lvl_ff <= MIN_LVL_RST;
      end else if (csr_we && (csr_index == REG_MIN_LVL)) begin
         min_lvl_ff <= csr_wdata[LVL_W-1:0];
      end
   end

   // sweep capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int k = 0; k < N_SENSORS; k++) begin
            time_ff[k] <= sweep[k*TIME_W +: TIME_W];
         end
      end
   end

   // current sensor operands
   logic [TIME_W-1:0] t_sel, w_sel, b_sel, t_ofs, span;
   logic              below, above, direct;
   assign t_sel  = time_ff[idx_ff];
   assign w_sel  = white_ff[idx_ff];
   assign b_sel  = black_ff[idx_ff];
   assign t_ofs  = t_sel - w_sel;
   assign span   = b_sel - w_sel;
   assign below  = t_sel < w_sel;
   assign above  = t_sel > b_sel;
   // under white, over black and a flat calibration take a fixed reflectance, not the quotient
   assign direct = below || above || (b_sel == w_sel);

   // divider operand select
   logic [DVD_W-1:0]   div_dvd;
   logic [DVS_W-1:0]   div_dvs;
   logic               div_start;
   logic [QUO_W-1:0]   quotient;
   logic               div_done;
   logic [SUM_W-1:0]   abs_sum;
   logic               sum_neg;

   assign sum_neg = sum_ff[SUM_W-1];
   assign abs_sum = sum_neg ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);

   always_comb begin
      if (cmd.cen_start) begin
         div_dvd = {abs_sum[SUM_W-2:0], {CEN_SH{1'b0}}};
         div_dvs = DVS_W'(total_ff) * DVS_W'(N_SENSORS - 1);
      end else begin
         div_dvd = DVD_W'({t_ofs, {REFL_SH{1'b0}}});
         div_dvs = DVS_W'(span);
      end
   end
   assign div_start = cmd.refl_start || cmd.cen_start;

   lce_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .quotient (quotient),
      .done     (div_done)
   );

   // reflectance and its weighted contribution
   logic [REFL_W-1:0]              refl;
   logic signed [WGT_W-1:0]        weight;
   logic signed [REFL_W+WGT_W:0]   prod;

   assign refl   = direct ? (below ? '0 : REFL_W'(1 << REFL_SH)) : quotient[REFL_W-1:0];
   assign weight = $signed({1'b0, idx_ff, 1'b0}) - WGT_OFS;
   assign prod   = $signed({1'b0, refl}) * weight;

   // centroid value and fallback
   logic signed [CEN_W-1:0] cen_val, fallback;
   logic                    no_line;
   assign cen_val  = sum_neg ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
   assign fallback = (last_ff < 0) ? CEN_NEG : ((last_ff > 0) ? CEN_POS : '0);
   assign no_line  = (total_ff == '0) || (total_ff < min_lvl_ff);

   always_comb begin
      idx_in    = idx_ff;
      sum_in    = sum_ff;
      total_in  = total_ff;
      last_in   = last_ff;
      center_in = center_ff;
      found_in  = found_ff;
      valid_in  = valid_ff && !rsp_tready;
      if (cmd.load) begin
         idx_in   = '0;
         sum_in   = '0;
         total_in = '0;
      end
      if (cmd.refl_acc) begin
         idx_in   = idx_ff + IDX_W'(1);
         sum_in   = sum_ff + SUM_W'(prod);
         total_in = total_ff + TOT_W'(refl);
      end
      if (cmd.finish) begin
         valid_in  = 1'b1;
         found_in  = !no_line;
         center_in = no_line ? fallback : cen_val;
         if (!no_line) begin
            last_in = cen_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         last_ff  <= last_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      sum_ff    <= sum_in;
      total_ff  <= total_in;
      center_ff <= center_in;
      found_ff  <= found_in;
   end

   assign sts.div_done    = div_done;
   assign sts.last_sensor = idx_ff == IDX_W'(N_SENSORS - 1);
   assign sts.no_line     = no_line;
   assign sts.out_free    = !valid_ff || rsp_tready;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = center_ff;
   assign rsp_tuser  = found_ff;

endmodule

>>> rtl/lce_ctrl.sv
// Controller: sequences sensors through the divider, then the centroid when a line is seen, then the result word.
`timescale 1ns / 1ps

module lce_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  lce_pkg::lce_sts_type sts,
   output lce_pkg::lce_cmd_type cmd
);
   import lce_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_REFL   = 3'd1;
   localparam logic [2:0] S_RWAIT  = 3'd2;
   localparam logic [2:0] S_CSTART = 3'd3;
   localparam logic [2:0] S_CWAIT  = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_REFL;
            end
         end
         S_REFL: begin
            cmd.refl_start = 1'b1;
            state_in       = S_RWAIT;
         end
         S_RWAIT: begin
            if (sts.div_done) begin
               cmd.refl_acc = 1'b1;
               state_in     = sts.last_sensor ? S_CSTART : S_REFL;
            end
         end
         S_CSTART: begin
            // no divide when the fallback answer is used
            if (sts.no_line) begin
               state_in = S_DONE;
            end else begin
               cmd.cen_start = 1'b1;
               state_in      = S_CWAIT;
            end
         end
         S_CWAIT: begin
            if (sts.div_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = state_ff == S_IDLE;

endmodule

>>> rtl/line_center_estimator.sv
// Top level of the line center estimator: stream ports, register port, controller and datapath.
`timescale 1ns / 1ps

// One input word is a sweep of eight 16-bit sensor discharge times; each is normalized
// against its white and black calibration into a Q1.12 reflectance, and one result word
// carries the reflectance centroid in Q2.14 (tdata) and a line-found flag (tuser). Below
// the minimum total level, or at zero total, the result is -1, +1 or 0 after the sign of
// the last found centroid, with the flag clear. All divides go through one shared restoring
// divider at one quotient bit per cycle. Each sweep is captured, each sensor is divided in
// turn, the centroid is divided unless no line is seen, and the result word is written;
// this last step waits while an earlier result still sits untaken in the output register.
// A new word is taken once the previous result sits in the output register, even if that
// result has not yet been taken. The user must write the calibration registers through the
// csr port only while the block is idle (not enforced by the block); there is no read-back.
module line_center_estimator (
   input  logic                                          clock,
   input  logic                                          reset,
   // register write port
   input  logic                                          csr_we,
   input  logic [lce_pkg::CSR_IDX_W-1:0]                 csr_index,
   input  logic [lce_pkg::CSR_DATA_W-1:0]                csr_wdata,
   // sweep words
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   input  logic [lce_pkg::N_SENSORS*lce_pkg::TIME_W-1:0] req_tdata,  // sensor0_time .. sensor7_time
   // result words
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   output logic [lce_pkg::CEN_W-1:0]                     rsp_tdata,  // line_center
   output logic [0:0]                                    rsp_tuser   // line_found
);
   import lce_pkg::*;

   lce_cmd_type cmd;
   lce_sts_type sts;

   lce_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lce_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .sweep      (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> rtl/lce_checker.sv
// Port-level checks of the line center estimator and their bind to the top level.
`timescale 1ns / 1ps

module lce_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [lce_pkg::CEN_W-1:0] rsp_tdata,
   input logic [0:0]                rsp_tuser
);
   import lce_pkg::*;

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // one sweep at a time: no word is taken right after one was taken
   a_one_sweep: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("sweep taken while previous one in work");

   // centroid stays within -1 .. +1
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata) >= CEN_NEG) && ($signed(rsp_tdata) <= CEN_POS))
      else $error("line center out of range");

   // fallback answer is only a full edge or center
   a_fallback: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |->
         ($signed(rsp_tdata) == CEN_NEG) || ($signed(rsp_tdata) == CEN_POS) ||
         (rsp_tdata == '0))
      else $error("fallback center not an edge or zero");

endmodule

bind line_center_estimator lce_checker u_lce_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
